// File: src/ffla_pkg.sv
// ----------------------------------------------------------------------------
// ffla_pkg
// Shared constants, codes and types of the frame free-list allocator.
// ----------------------------------------------------------------------------
package ffla_pkg;

    // frame geometry
    localparam int unsigned FRAME_CAP   = 1024;
    localparam int unsigned FRAME_BYTES = 4096;
    localparam int unsigned FRAME_SHIFT = $clog2(FRAME_BYTES);
    localparam int unsigned IDX_W       = $clog2(FRAME_CAP);
    localparam int unsigned LINK_W      = $clog2(FRAME_CAP + 1);
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned ADDR_W      = 22;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned QUOT_W      = WORD_W - FRAME_SHIFT;
    localparam int unsigned STATUS_W    = 2;

    // stream payload widths
    localparam int unsigned IN_DATA_W   = WORD_W;
    localparam int unsigned OUT_FIELD_W = ADDR_W + 3 * CNT_W;
    localparam int unsigned OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

    // null link marker, no valid index
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(FRAME_CAP);

    // operation kinds
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE         = 2'd0,
        STAT_NO_FRAME     = 2'd1,
        STAT_OUT_OF_RANGE = 2'd2
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        S_SWEEP,
        S_IDLE,
        S_EXEC
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic cfg_wr;
        logic sweep_wr;
        logic accept;
        logic commit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic sweep_last;
        logic out_free;
    } t_sts;

endpackage

// File: src/ffla_ram.sv
// ----------------------------------------------------------------------------
// ffla_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ffla_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/ffla_ctrl.sv
// ----------------------------------------------------------------------------
// ffla_ctrl
// Controller: link memory rebuild sweep, item accept and commit sequencing.
// ----------------------------------------------------------------------------
module ffla_ctrl
    import ffla_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_wr,
    input  logic i_item_valid,
    input  t_sts i_sts,
    output logic o_item_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (i_cfg_wr) begin
            n_state = S_SWEEP;
        end else begin
            unique case (r_state)
                S_SWEEP: begin
                    if (i_sts.sweep_last) n_state = S_IDLE;
                end
                S_IDLE: begin
                    if (i_item_valid) n_state = S_EXEC;
                end
                S_EXEC: begin
                    if (i_sts.out_free) n_state = S_IDLE;
                end
                default: n_state = S_SWEEP;
            endcase
        end
    end

    // outputs, no item taken in the cycle of a configuration write
    always_comb begin
        o_item_ready    = 1'b0;
        o_cmd.cfg_wr    = i_cfg_wr;
        o_cmd.sweep_wr  = 1'b0;
        o_cmd.accept    = 1'b0;
        o_cmd.commit    = 1'b0;
        unique case (r_state)
            S_SWEEP: begin
                o_cmd.sweep_wr = 1'b1;
            end
            S_IDLE: begin
                o_item_ready = !i_cfg_wr;
                o_cmd.accept = i_item_valid && !i_cfg_wr;
            end
            S_EXEC: begin
                o_cmd.commit = i_sts.out_free;
            end
            default: begin
                o_item_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/ffla_dpath.sv
// ----------------------------------------------------------------------------
// ffla_dpath
// Datapath: link memory, list head, counters and the output register.
// ----------------------------------------------------------------------------
module ffla_dpath
    import ffla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic [WORD_W-1:0]     i_cfg_data,
    input  logic                  i_kind,
    input  logic [WORD_W-1:0]     i_frame_address,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [STATUS_W-1:0]   o_status,
    output logic [OUT_DATA_W-1:0] o_out_data
);

    // list state
    logic [CNT_W-1:0]  r_total;
    logic [CNT_W-1:0]  n_total;
    logic [LINK_W-1:0] r_head;
    logic [LINK_W-1:0] n_head;
    logic [CNT_W-1:0]  r_free;
    logic [CNT_W-1:0]  n_free;
    logic [IDX_W-1:0]  r_sweep_idx;

    // latched item
    logic              r_kind;
    logic [QUOT_W-1:0] r_idx;

    // output register
    logic                r_out_valid;
    t_status             r_status;
    logic [ADDR_W-1:0]   r_granted;
    logic [CNT_W-1:0]    r_free_out;
    logic [CNT_W-1:0]    r_used_out;
    logic [CNT_W-1:0]    r_total_out;

    // memory ports
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [LINK_W-1:0] ram_wdata;
    logic [LINK_W-1:0] ram_rdata;

    // commit results
    t_status           n_status;
    logic [ADDR_W-1:0] n_granted;
    logic              head_null;
    logic              idx_in_range;
    logic [LINK_W-1:0] sweep_next;
    logic [QUOT_W-1:0] cfg_quot;

    // frame count from the configured byte size
    always_comb begin
        cfg_quot = i_cfg_data[WORD_W-1:FRAME_SHIFT];
        if (cfg_quot >= QUOT_W'(FRAME_CAP)) begin
            n_total = CNT_W'(FRAME_CAP);
        end else begin
            n_total = cfg_quot[CNT_W-1:0];
        end
    end

    // rebuild value of the swept entry
    assign sweep_next = LINK_W'(r_sweep_idx) + LINK_W'(1);

    // link memory, read always at the list head
    ffla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (FRAME_CAP)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_head[IDX_W-1:0]),
        .o_rdata (ram_rdata)
    );

    // write port: rebuild sweep or push of a freed frame
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_sweep_idx;
        ram_wdata = LINK_NULL;
        if (i_cmd.sweep_wr) begin
            ram_we = 1'b1;
            if (CNT_W'(sweep_next) < r_total) begin
                ram_wdata = sweep_next;
            end
        end else if (i_cmd.commit && r_kind == KIND_FREE && idx_in_range) begin
            ram_we    = 1'b1;
            ram_waddr = r_idx[IDX_W-1:0];
            ram_wdata = r_head;
        end
    end

    // allocate pops the head, free pushes the index
    always_comb begin
        head_null    = (r_head >= LINK_NULL) || (r_free == '0);
        idx_in_range = r_idx < QUOT_W'(r_total);
        n_head       = r_head;
        n_free       = r_free;
        n_status     = STAT_DONE;
        n_granted    = '0;
        if (r_kind == KIND_ALLOC) begin
            if (head_null) begin
                n_status = STAT_NO_FRAME;
            end else begin
                n_head    = ram_rdata;
                n_free    = r_free - CNT_W'(1);
                n_granted = ADDR_W'(r_head[IDX_W-1:0]) << FRAME_SHIFT;
            end
        end else begin
            if (!idx_in_range) begin
                n_status = STAT_OUT_OF_RANGE;
            end else begin
                n_head = LINK_W'(r_idx[IDX_W-1:0]);
                n_free = r_free + CNT_W'(1);
            end
        end
    end

    // list state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= CNT_W'(FRAME_CAP);
            r_head      <= '0;
            r_free      <= CNT_W'(FRAME_CAP);
            r_sweep_idx <= '0;
        end else if (i_cmd.cfg_wr) begin
            r_total     <= n_total;
            r_head      <= (n_total == '0) ? LINK_NULL : '0;
            r_free      <= n_total;
            r_sweep_idx <= '0;
        end else begin
            if (i_cmd.sweep_wr) begin
                r_sweep_idx <= r_sweep_idx + IDX_W'(1);
            end
            if (i_cmd.commit) begin
                r_head <= n_head;
                r_free <= n_free;
            end
        end
    end

    // item capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind <= i_kind;
            r_idx  <= i_frame_address[WORD_W-1:FRAME_SHIFT];
        end
    end

    // output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status    <= n_status;
            r_granted   <= n_granted;
            r_free_out  <= n_free;
            r_used_out  <= r_total - n_free;
            r_total_out <= r_total;
        end
    end

    assign o_sts.sweep_last = (r_sweep_idx == IDX_W'(FRAME_CAP - 1));
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_out_data  = OUT_DATA_W'({r_total_out, r_used_out, r_free_out, r_granted});

endmodule

// File: src/frame_free_list_allocator.sv
// ----------------------------------------------------------------------------
// frame_free_list_allocator
// Page-frame allocator with a linked free list of frame indices held in a
// link RAM; allocate pops the head, free pushes a frame back on the head.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------
//  s (item) | in        | i_s_tvalid/o_s_tready| tuser kind, tdata frame_address
//  m (res)  | out       | o_m_tvalid/i_m_tready| tuser status, tdata counts
//  cfg      | in        | i_cfg_valid/o_cfg_rdy| cfg_data memory_bytes
//
//  Each item is accepted in S_IDLE and committed in S_EXEC once the registered
//  read of the head's link from the link RAM is available.
//  After reset and after every configuration write the link RAM is rebuilt by
//  a sweep over every entry, one entry per cycle, with o_s_tready low.
//  A result waits in the output register; the next item is accepted while it
//  waits, and its commit stalls until the output register is free.
// ----------------------------------------------------------------------------
module frame_free_list_allocator
    import ffla_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // item stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_DATA_W-1:0]  i_s_tdata,   // [31:0] frame_address
    input  logic                  i_s_tuser,   // [0] kind
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // granted_address, free_count,
                                               // used_count, total_count, pad
    output logic [STATUS_W-1:0]   o_m_tuser,   // [1:0] status
    // configuration write
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [WORD_W-1:0]     i_cfg_data   // memory_bytes
);

    t_cmd cmd;
    t_sts sts;
    logic cfg_wr;

    // configuration is taken at any time
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    // controller
    ffla_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr     (cfg_wr),
        .i_item_valid (i_s_tvalid),
        .i_sts        (sts),
        .o_item_ready (o_s_tready),
        .o_cmd        (cmd)
    );

    // datapath
    ffla_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_s_tuser),
        .i_frame_address (i_s_tdata),
        .o_out_valid     (o_m_tvalid),
        .i_out_ready     (i_m_tready),
        .o_status        (o_m_tuser),
        .o_out_data      (o_m_tdata)
    );

endmodule

// File: src/ffla_checker.sv
// ----------------------------------------------------------------------------
// ffla_checker
// Port-level checks of the frame free-list allocator, bound to the top level.
// ----------------------------------------------------------------------------
module ffla_checker
    import ffla_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic [STATUS_W-1:0]   o_m_tuser,
    input logic                  i_cfg_valid,
    input logic                  o_cfg_ready
);

    // free and used counts always add up to the total
    a_count_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (CNT_W'(o_m_tdata[32:22] + o_m_tdata[43:33]) == o_m_tdata[54:44]))
        else $error("free plus used differs from total");

    // a failed or ignored item grants no address
    a_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser != STAT_DONE) |-> (o_m_tdata[21:0] == '0))
        else $error("address granted on a failed item");

    // one item at a time: no accept right after an accept
    a_item_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("item accepted in back-to-back cycles");

    // a configuration write starts the rebuild sweep
    a_cfg_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cfg_valid && o_cfg_ready) |=> !o_s_tready)
        else $error("item port open right after configuration write");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)))
        else $error("stalled result changed");

endmodule

bind frame_free_list_allocator ffla_checker u_ffla_checker (.*);

// File: test/frame_free_list_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_free_list_allocator_tb
// Self-checking bench for the frame allocator. A scoreboard class keeps its
// own free list, counters and frame total, predicts every result from the
// accepted requests and compares the result stream field by field. Directed
// corner cases come first. Random allocate/free traffic follows, under several
// memory sizes, and then a run of frees that wraps the free counter.
// ----------------------------------------------------------------------------
module frame_free_list_allocator_tb;
    import ffla_pkg::*;

    localparam logic [WORD_W-1:0] RESET_MEMORY_BYTES = 32'd4194304;
    localparam int unsigned       MIXED_PER_SIZE     = 45;

    // expected fields of one result transaction
    typedef struct {
        t_status           status;
        logic [ADDR_W-1:0] granted;
        logic [CNT_W-1:0]  free_cnt;
        logic [CNT_W-1:0]  used_cnt;
        logic [CNT_W-1:0]  total_cnt;
    } t_frame_reply;

    // shadow free list and queue of predicted results
    class t_frame_ledger;
        logic [LINK_W-1:0] next_link [FRAME_CAP];
        logic [LINK_W-1:0] head;
        logic [CNT_W-1:0]  free_cnt;
        int unsigned       total;
        t_frame_reply      pending [$];
        int unsigned       mismatches;
        int unsigned       requests;
        int unsigned       grants;
        int unsigned       refusals;

        function void rebuild(logic [WORD_W-1:0] mem_bytes);
            int unsigned n;
            int unsigned i;
            n = mem_bytes / FRAME_BYTES;
            if (n > FRAME_CAP) begin
                n = FRAME_CAP;
            end
            total = n;
            for (i = 0; i < FRAME_CAP; i++) begin
                next_link[i] = (i + 1 < n) ? LINK_W'(i + 1) : LINK_NULL;
            end
            head     = (n == 0) ? LINK_NULL : '0;
            free_cnt = CNT_W'(n);
        endfunction

        // pop or push the list for one accepted request
        function t_frame_reply note_request(logic kind, logic [WORD_W-1:0] addr);
            t_frame_reply r;
            int unsigned  idx;
            r.status  = STAT_DONE;
            r.granted = '0;
            if (kind == KIND_ALLOC) begin
                if (head >= FRAME_CAP || free_cnt == 0) begin
                    r.status = STAT_NO_FRAME;
                end else begin
                    idx       = head;
                    head      = next_link[idx];
                    free_cnt  = free_cnt - 1'b1;
                    r.granted = ADDR_W'(idx * FRAME_BYTES);
                end
            end else begin
                idx = addr / FRAME_BYTES;
                if (idx >= total) begin
                    r.status = STAT_OUT_OF_RANGE;
                end else begin
                    next_link[idx] = head;
                    head           = LINK_W'(idx);
                    free_cnt       = free_cnt + 1'b1;
                end
            end
            r.free_cnt  = free_cnt;
            r.used_cnt  = CNT_W'(total - free_cnt);
            r.total_cnt = CNT_W'(total);
            pending.push_back(r);
            requests++;
            return r;
        endfunction

        function void check_reply(logic [STATUS_W-1:0] status, logic [OUT_DATA_W-1:0] data);
            t_frame_reply     e;
            logic [CNT_W-1:0] free_got;
            logic [CNT_W-1:0] used_got;
            logic [CNT_W-1:0] total_got;
            if (pending.size() == 0) begin
                $error("result with no request outstanding: status %0d data %h", status, data);
                mismatches++;
                return;
            end
            e         = pending.pop_front();
            free_got  = data[ADDR_W +: CNT_W];
            used_got  = data[ADDR_W + CNT_W +: CNT_W];
            total_got = data[ADDR_W + 2 * CNT_W +: CNT_W];
            if (e.status == STAT_DONE) begin
                grants++;
            end else begin
                refusals++;
            end
            if (status !== e.status) begin
                $error("status: expected %0d, got %0d", e.status, status);
                mismatches++;
            end
            if (data[ADDR_W-1:0] !== e.granted) begin
                $error("granted_address: expected %h, got %h", e.granted, data[ADDR_W-1:0]);
                mismatches++;
            end
            if (free_got !== e.free_cnt) begin
                $error("free_count: expected %0d, got %0d", e.free_cnt, free_got);
                mismatches++;
            end
            if (used_got !== e.used_cnt) begin
                $error("used_count: expected %0d, got %0d", e.used_cnt, used_got);
                mismatches++;
            end
            if (total_got !== e.total_cnt) begin
                $error("total_count: expected %0d, got %0d", e.total_cnt, total_got);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata   = '0;
    logic                  i_s_tuser   = KIND_ALLOC;
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic [STATUS_W-1:0]   o_m_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [WORD_W-1:0]     i_cfg_data  = '0;

    t_frame_ledger ledger;
    int unsigned held [$];      // granted addresses not yet freed
    bit          idles_on = 1'b1;
    int unsigned sizes_used;

    frame_free_list_allocator i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // 50 MHz clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // random back-pressure on the result stream
    always @(posedge i_clk) begin
        i_m_tready <= !idles_on || ($urandom_range(99) >= 19);
    end

    // result monitor, sees pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            ledger.check_reply(o_m_tuser, o_m_tdata);
        end
    end

    // one request transaction, with an occasional gap in front
    task automatic send_request(input logic kind, input logic [WORD_W-1:0] addr);
        t_frame_reply r;
        if (idles_on && $urandom_range(99) < 19) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= addr;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        r = ledger.note_request(kind, addr);
        if (kind == KIND_ALLOC && r.status == STAT_DONE) begin
            held.push_back(int'(r.granted));
        end
    endtask

    // memory size write once every result is back; the list is rebuilt
    task automatic set_memory_size(input logic [WORD_W-1:0] bytes);
        i_s_tvalid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bytes;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ledger.rebuild(bytes);
        held.delete();
        sizes_used++;
    endtask

    // allocates, frees of granted frames, stray and out-of-range frees
    task automatic run_mixed_traffic(input int unsigned count);
        int unsigned pick;
        int unsigned slot;
        int unsigned addr;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 50) begin
                send_request(KIND_ALLOC, $urandom);
            end else if (pick < 78 && held.size() != 0) begin
                slot = $urandom_range(held.size() - 1);
                addr = held[slot] | $urandom_range(FRAME_BYTES - 1);
                held.delete(slot);
                send_request(KIND_FREE, addr);
            end else if (pick < 90) begin
                // index up to one past the last frame
                addr = ($urandom_range(ledger.total) << FRAME_SHIFT)
                       | $urandom_range(FRAME_BYTES - 1);
                send_request(KIND_FREE, addr);
            end else begin
                send_request(KIND_FREE, $urandom);
            end
        end
    endtask

    // enough repeated frees on a full list to wrap the free counter to zero
    task automatic run_counter_wrap();
        int unsigned addr;
        set_memory_size(32'hFFFF_FFFF);
        idles_on = 1'b0;
        repeat (FRAME_CAP) begin
            addr = ($urandom_range(FRAME_CAP - 1) << FRAME_SHIFT)
                   | $urandom_range(FRAME_BYTES - 1);
            send_request(KIND_FREE, addr);
        end
        send_request(KIND_ALLOC, $urandom);
        send_request(KIND_ALLOC, $urandom);
        send_request(KIND_FREE, 32'h0000_5000);
        send_request(KIND_ALLOC, $urandom);
        send_request(KIND_ALLOC, $urandom);
        idles_on = 1'b1;
    endtask

    // watchdog
    initial begin
        #10_000_000;
        $display("frame_free_list_allocator_tb: errors");
        $finish;
    end

    initial begin
        logic [WORD_W-1:0] mixed_sizes [6];
        int unsigned       k;
        ledger = new();
        ledger.rebuild(RESET_MEMORY_BYTES);
        sizes_used = 1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full size after reset: grants, unaligned, out of range, double free
        send_request(KIND_ALLOC, 32'h0000_0000);
        send_request(KIND_ALLOC, 32'hFFFF_FFFF);
        send_request(KIND_FREE, 32'h0000_1FFF);
        send_request(KIND_FREE, 32'hFFFF_FFFF);
        send_request(KIND_FREE, 32'h0040_0000);
        send_request(KIND_FREE, 32'h003F_F000);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_ALLOC, 32'h0);

        // no frames at all
        set_memory_size(32'h0000_0000);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_FREE, 32'h0000_0000);
        send_request(KIND_FREE, 32'hFFFF_FFFF);
        set_memory_size(32'h0000_0FFF);
        send_request(KIND_ALLOC, 32'h0);

        // single frame: empty list, then a self-linked list with zero count
        set_memory_size(32'h0000_1000);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_FREE, 32'h0000_0FFF);
        send_request(KIND_FREE, 32'h0000_1000);
        send_request(KIND_FREE, 32'h0000_0000);
        send_request(KIND_FREE, 32'h0000_0000);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_ALLOC, 32'h0);
        send_request(KIND_ALLOC, 32'h0);

        // random traffic over several memory sizes
        mixed_sizes[0] = 5 * FRAME_BYTES + 17;
        mixed_sizes[1] = 32'hFFFF_FFFF;
        mixed_sizes[2] = $urandom;
        mixed_sizes[3] = $urandom_range(40, 2) * FRAME_BYTES;
        mixed_sizes[4] = 32'h003F_FFFF;
        mixed_sizes[5] = 3 * FRAME_BYTES;
        for (k = 0; k < 6; k++) begin
            set_memory_size(mixed_sizes[k]);
            run_mixed_traffic(MIXED_PER_SIZE);
        end

        run_counter_wrap();

        set_memory_size(RESET_MEMORY_BYTES);
        run_mixed_traffic(40);

        // drain
        i_s_tvalid <= 1'b0;
        while (ledger.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run: %0d requests under %0d memory sizes", ledger.requests, sizes_used);
        $display("run: %0d grants or frees done, %0d refused", ledger.grants, ledger.refusals);
        if (ledger.mismatches == 0 && ledger.pending.size() == 0) begin
            $display("frame_free_list_allocator_tb: clean");
        end else begin
            $display("frame_free_list_allocator_tb: errors");
        end
        $finish;
    end

endmodule

// File: sim.f
src/ffla_pkg.sv
src/ffla_ram.sv
src/ffla_ctrl.sv
src/ffla_dpath.sv
src/frame_free_list_allocator.sv
src/ffla_checker.sv
test/frame_free_list_allocator_tb.sv
